// ===== rtl/mcctb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcctb_pkg
// Shared types, codes and field widths of the countdown timer bank.
// ----------------------------------------------------------------------------
package mcctb_pkg;

    localparam int CHANNELS_DEFAULT = 8;

    localparam int CMD_W    = 3;
    localparam int CHAN_W   = 3;
    localparam int TIME_W   = 32;
    localparam int DEC_W    = 16;
    localparam int MASK_W   = 8;

    // channel, time_value, periodic_flag, notify_flag -> 37 bits, padded to 40
    localparam int IN_TDATA_W  = 40;
    // expired_mask, is_running, top_flag, remaining_time, elapsed_time -> 74, padded
    localparam int OUT_TDATA_W = 80;

    // One RAM word: reload count in the upper half, remaining count in the lower
    localparam int WORD_W = 2 * TIME_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_CONFIGURE  = 3'd1,
        CMD_SET_RELOAD = 3'd2,
        CMD_START      = 3'd3,
        CMD_STOP       = 3'd4,
        CMD_QUERY      = 3'd5,
        CMD_TAKE_TOP   = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK
    } state_t;

endpackage

// ===== rtl/multi_channel_countdown_timer_bank.sv =====
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_bank
// Bank of countdown timer channels, counts held in one RAM and walked by a
// small sequencer through one shared subtractor.
//
//   channel   direction  handshake                 carries
//   s_axis    in         tvalid/tready             command (tuser) and operands
//   m_axis    out        tvalid/tready             one result per command
//   cfg       in         cfg_valid/cfg_ready       tick_decrement
//
// A tick walks every channel in turn: the RAM read port visits one channel per
// cycle, the subtractor updates the channel read the cycle before. Every other
// command does one RAM read, then one update once the result register is free.
// Reset clears control state, sets the tick decrement to 1 and marks every RAM
// entry invalid; an invalid entry reads as zero. A result waiting on m_axis does
// not stop the next transfer; it holds only the next result and a command's update.
// ----------------------------------------------------------------------------
module multi_channel_countdown_timer_bank #(
    parameter int CHANNELS = mcctb_pkg::CHANNELS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] channel, [34:3] time_value, [35] periodic_flag, [36] notify_flag
    input  logic [mcctb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] command
    input  logic [mcctb_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] expired_mask, [8] is_running, [9] top_flag,
    // [41:10] remaining_time, [73:42] elapsed_time
    output logic [mcctb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcctb_pkg::DEC_W-1:0]       cfg_data
);

    import mcctb_pkg::*;

    localparam int AW = $clog2(CHANNELS);

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic                   ch_ok_reg, ch_ok_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [TIME_W-1:0]      tv_reg, tv_next;
    logic                   per_reg, per_next;
    logic                   ntf_reg, ntf_next;
    logic [AW:0]            rd_cnt_reg, rd_cnt_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic [AW-1:0]          pipe_idx_reg, pipe_idx_next;
    logic [MASK_W-1:0]      mask_reg, mask_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [CHANNELS-1:0]    vld_reg, vld_next;
    logic [CHANNELS-1:0]    running_reg, running_next;
    logic [CHANNELS-1:0]    periodic_reg, periodic_next;
    logic [CHANNELS-1:0]    notify_reg, notify_next;
    logic [CHANNELS-1:0]    top_reg, top_next;
    logic [DEC_W-1:0]       dec_reg, dec_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [WORD_W-1:0]      ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [WORD_W-1:0]      ram_rd_data;

    logic [TIME_W-1:0]      sub_a, sub_b, sub_diff;
    logic                   sub_borrow;

    logic [TIME_W-1:0]      cur_rem, cur_reload;
    logic [AW-1:0]          in_addr;
    logic                   in_ok;
    logic [AW-1:0]          scan_addr;
    logic                   slot_free;
    logic [MASK_W-1:0]      res_mask;
    logic                   res_run, res_top;
    logic [TIME_W-1:0]      res_rem, res_elapsed;

    mcctb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mcctb_sub u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign cur_rem    = rd_vld_reg ? ram_rd_data[TIME_W-1:0] : '0;
    assign cur_reload = rd_vld_reg ? ram_rd_data[WORD_W-1:TIME_W] : '0;

    assign in_addr   = AW'(s_axis_tdata[CHAN_W-1:0]);
    assign in_ok     = int'(s_axis_tdata[CHAN_W-1:0]) < CHANNELS;
    assign scan_addr = rd_cnt_reg[AW-1:0];
    assign slot_free = !out_valid_reg || m_axis_tready;

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            pipe_vld_reg  <= 1'b0;
            mask_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            vld_reg       <= '0;
            running_reg   <= '0;
            periodic_reg  <= '0;
            notify_reg    <= '0;
            top_reg       <= '0;
            dec_reg       <= DEC_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            pipe_vld_reg  <= pipe_vld_next;
            mask_reg      <= mask_next;
            rd_vld_reg    <= rd_vld_next;
            vld_reg       <= vld_next;
            running_reg   <= running_next;
            periodic_reg  <= periodic_next;
            notify_reg    <= notify_next;
            top_reg       <= top_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ch_ok_reg    <= ch_ok_next;
        addr_reg     <= addr_next;
        tv_reg       <= tv_next;
        per_reg      <= per_next;
        ntf_reg      <= ntf_next;
        pipe_idx_reg <= pipe_idx_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ch_ok_next     = ch_ok_reg;
        addr_next      = addr_reg;
        tv_next        = tv_reg;
        per_next       = per_reg;
        ntf_next       = ntf_reg;
        rd_cnt_next    = rd_cnt_reg;
        pipe_vld_next  = pipe_vld_reg;
        pipe_idx_next  = pipe_idx_reg;
        mask_next      = mask_reg;
        rd_vld_next    = rd_vld_reg;
        vld_next       = vld_reg;
        running_next   = running_reg;
        periodic_next  = periodic_reg;
        notify_next    = notify_reg;
        top_next       = top_reg;
        dec_next       = dec_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = addr_reg;
        sub_a       = cur_reload;
        sub_b       = cur_rem;

        res_mask    = '0;
        res_run     = 1'b0;
        res_top     = 1'b0;
        res_rem     = '0;
        res_elapsed = '0;

        s_axis_tready = (state_reg == ST_IDLE);

        if (cfg_valid)
        begin
            dec_next = cfg_data;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = cmd_t'(s_axis_tuser);
                    ch_ok_next = in_ok;
                    addr_next  = in_addr;
                    tv_next    = s_axis_tdata[CHAN_W +: TIME_W];
                    per_next   = s_axis_tdata[CHAN_W + TIME_W];
                    ntf_next   = s_axis_tdata[CHAN_W + TIME_W + 1];
                    if (cmd_t'(s_axis_tuser) == CMD_TICK)
                    begin
                        rd_cnt_next   = '0;
                        pipe_vld_next = 1'b0;
                        mask_next     = '0;
                        state_next    = ST_TICK;
                    end
                    else
                    begin
                        // fetch the addressed entry for the update cycle
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = in_addr;
                        rd_vld_next = in_ok && vld_reg[in_addr];
                        state_next  = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                // hold the update until the result register can take it
                if (slot_free)
                begin
                    ram_wr_addr = addr_reg;
                    if (ch_ok_reg)
                    begin
                        unique case (cmd_reg)
                            CMD_CONFIGURE:
                            begin
                                ram_wr_en               = 1'b1;
                                ram_wr_data             = {tv_reg, tv_reg};
                                vld_next[addr_reg]      = 1'b1;
                                periodic_next[addr_reg] = per_reg;
                                notify_next[addr_reg]   = ntf_reg;
                                running_next[addr_reg]  = 1'b0;
                            end
                            CMD_SET_RELOAD:
                            begin
                                ram_wr_en          = 1'b1;
                                ram_wr_data        = {tv_reg, cur_rem};
                                vld_next[addr_reg] = 1'b1;
                            end
                            CMD_START:
                            begin
                                ram_wr_en              = 1'b1;
                                ram_wr_data            = {cur_reload, cur_reload};
                                vld_next[addr_reg]     = 1'b1;
                                top_next[addr_reg]     = 1'b0;
                                running_next[addr_reg] = 1'b1;
                            end
                            CMD_STOP:
                            begin
                                running_next[addr_reg] = 1'b0;
                            end
                            CMD_QUERY:
                            begin
                                res_run     = running_reg[addr_reg];
                                res_top     = top_reg[addr_reg];
                                res_rem     = cur_rem;
                                res_elapsed = sub_diff;
                            end
                            CMD_TAKE_TOP:
                            begin
                                res_top            = top_reg[addr_reg];
                                top_next[addr_reg] = 1'b0;
                            end
                            default:
                            begin
                                res_top = 1'b0;
                            end
                        endcase
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({res_elapsed, res_rem, res_top,
                                                   res_run, res_mask});
                    state_next     = ST_IDLE;
                end
            end

            ST_TICK:
            begin
                // issue the read of the next channel
                if (rd_cnt_reg < (AW+1)'(CHANNELS))
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = scan_addr;
                    rd_vld_next   = vld_reg[scan_addr];
                    pipe_idx_next = scan_addr;
                    pipe_vld_next = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                end
                else
                begin
                    pipe_vld_next = 1'b0;
                end

                // update the channel read in the previous cycle
                if (pipe_vld_reg && running_reg[pipe_idx_reg])
                begin
                    sub_a       = cur_rem;
                    sub_b       = TIME_W'(dec_reg);
                    ram_wr_addr = pipe_idx_reg;
                    if (cur_rem == '0)
                    begin
                        running_next[pipe_idx_reg] = 1'b0;
                    end
                    else if (!sub_borrow && sub_diff != '0)
                    begin
                        ram_wr_en              = 1'b1;
                        ram_wr_data            = {cur_reload, sub_diff};
                        vld_next[pipe_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        // expired: report, then reload or drop out
                        if (notify_reg[pipe_idx_reg])
                        begin
                            if (int'(pipe_idx_reg) < MASK_W)
                            begin
                                mask_next[3'(pipe_idx_reg)] = 1'b1;
                            end
                        end
                        else
                        begin
                            top_next[pipe_idx_reg] = 1'b1;
                        end
                        ram_wr_en              = 1'b1;
                        vld_next[pipe_idx_reg] = 1'b1;
                        if (periodic_reg[pipe_idx_reg])
                        begin
                            ram_wr_data = {cur_reload, cur_reload};
                        end
                        else
                        begin
                            ram_wr_data                = {cur_reload, TIME_W'(0)};
                            running_next[pipe_idx_reg] = 1'b0;
                        end
                    end
                end

                if (!pipe_vld_reg && rd_cnt_reg == (AW+1)'(CHANNELS) && slot_free)
                begin
                    res_mask       = mask_reg;
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({res_elapsed, res_rem, res_top,
                                                   res_run, res_mask});
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mcctb_ram.sv =====
// ----------------------------------------------------------------------------
// mcctb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcctb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/mcctb_sub.sv =====
// ----------------------------------------------------------------------------
// mcctb_sub
// Shared 32-bit subtractor with borrow: countdown on ticks, elapsed on query.
// ----------------------------------------------------------------------------
module mcctb_sub (
    input  logic [mcctb_pkg::TIME_W-1:0] a,
    input  logic [mcctb_pkg::TIME_W-1:0] b,
    output logic [mcctb_pkg::TIME_W-1:0] diff,
    output logic                         borrow
);

    import mcctb_pkg::*;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule
